// ----- design/lpte_pkg.sv -----
// ----------------------------------------------------------------------------
// lpte_pkg
// shared types and constants of the lane passing time estimator
// ----------------------------------------------------------------------------
package lpte_pkg;

   localparam int FRAC_BITS = 8;
   localparam int SPEED_W = 16;
   localparam int DIST_W = 16;
   localparam int TIME_W = 32;
   localparam int SQ_W = 34;
   localparam int QUO_W = DIST_W + FRAC_BITS;
   localparam int ROOT_STEPS = SQ_W / 2;

   localparam logic [SPEED_W-1:0] SPEED_FLOOR = SPEED_W'(((1 << FRAC_BITS) + 5) / 10);
   localparam logic [TIME_W-1:0] TIME_MAX = '1;

   localparam logic CSR_MAX_ACCEL = 1'b0;
   localparam logic CSR_MAX_SPEED = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SQ_A,
      ST_SQ_B,
      ST_ROOT,
      ST_MEAN,
      ST_DIV,
      ST_ACC,
      ST_OUT
   } state_type;

endpackage

// ----- design/lpte_if.sv -----
// ----------------------------------------------------------------------------
// lpte_req_if / lpte_rsp_if
// valid/ready channels of the estimator
// ----------------------------------------------------------------------------
interface lpte_req_if;
   logic        valid;
   logic        ready;
   logic        first_segment;
   logic [15:0] start_speed;
   logic [15:0] seg_dist;
   logic        in_lane;
   logic        last_point;

   modport source (output valid, first_segment, start_speed, seg_dist, in_lane,
                   last_point, input ready);
   modport sink (input valid, first_segment, start_speed, seg_dist, in_lane,
                 last_point, output ready);
endinterface

interface lpte_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] pass_time;
   logic        lane_reached;

   modport source (output valid, pass_time, lane_reached, input ready);
   modport sink (input valid, pass_time, lane_reached, output ready);
endinterface

// ----- design/lane_passing_time_estimator_top.sv -----
// ----------------------------------------------------------------------------
// lane_passing_time_estimator_top
// per segment speed update and time accumulation; root and divide share one subtract unit
// ----------------------------------------------------------------------------
//  channel | dir | contents
//  req     | in  | first_segment, start_speed, seg_dist, in_lane, last_point
//  rsp     | out | pass_time, lane_reached (on last_point only)
//  csr     | in  | max_accel (0), max_speed (1)
//
//  a counted segment runs sq_a, sq_b, root, mean, div, acc and out, then
//  idle; the root and the divider each run one bit a cycle on the shared
//  subtractor. a segment after the run ended goes from idle straight to out.
//  reset is synchronous; state clears, csr registers load their defaults.
//  a new word is taken while a result waits; a last segment then holds in the
//  output state until rsp takes the older word.
// ----------------------------------------------------------------------------
module lane_passing_time_estimator_top (
   input  logic        clock,
   input  logic        reset,
   lpte_req_if.sink    req,
   lpte_rsp_if.source  rsp,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);
   import lpte_pkg::*;

   state_type state_ff, state_in;
   logic [15:0] accel_ff, vmax_ff;
   logic [SPEED_W-1:0] speed_ff, speed_in;
   logic [TIME_W-1:0] tsum_ff, tsum_in;
   logic seen_ff, seen_in, done_ff, done_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   logic inl_ff, inl_in, last_ff, last_in;
   logic [SQ_W-1:0] rem_ff, rem_in;
   logic [SQ_W-1:0] acc_ff, acc_in;       // root / quotient
   logic [4:0] cnt_ff, cnt_in;
   logic [SPEED_W-1:0] next_ff, next_in;
   logic rv_ff, rv_in;
   logic [TIME_W-1:0] rt_ff, rt_in;
   logic rl_ff, rl_in;

   // shared subtract unit
   logic [SQ_W:0] sub_a, sub_b, sub_r;
   assign sub_r = sub_a - sub_b;

   // shared multiplier, v*v then a*d
   logic [SPEED_W-1:0] mul_a, mul_b;
   logic [SQ_W-1:0] mul_p;
   assign mul_p = SQ_W'(mul_a) * SQ_W'(mul_b);

   logic [SQ_W-1:0] bitv, trial;
   logic [SPEED_W:0] sumv;
   logic [SPEED_W-1:0] mean;
   logic [TIME_W:0] tadd;
   logic [QUO_W-1:0] num;

   assign bitv = SQ_W'(1) << {cnt_ff, 1'b0};
   assign trial = acc_ff + bitv;
   assign num = {dist_ff, FRAC_BITS'(0)};
   assign sumv = {1'b0, speed_ff} + {1'b0, next_ff};
   assign tadd = {1'b0, tsum_ff} + {1'b0, acc_ff[TIME_W-1:0]};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         accel_ff <= 16'd256;
         vmax_ff <= 16'd711;
         speed_ff <= '0;
         tsum_ff <= '0;
         seen_ff <= 1'b0;
         done_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         speed_ff <= speed_in;
         tsum_ff <= tsum_in;
         seen_ff <= seen_in;
         done_ff <= done_in;
         rv_ff <= rv_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_MAX_ACCEL: accel_ff <= csr_wdata;
               CSR_MAX_SPEED: vmax_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      dist_ff <= dist_in;
      inl_ff <= inl_in;
      last_ff <= last_in;
      rem_ff <= rem_in;
      acc_ff <= acc_in;
      cnt_ff <= cnt_in;
      next_ff <= next_in;
      rt_ff <= rt_in;
      rl_ff <= rl_in;
   end

   always_comb begin
      state_in = state_ff;
      speed_in = speed_ff;
      tsum_in = tsum_ff;
      seen_in = seen_ff;
      done_in = done_ff;
      dist_in = dist_ff;
      inl_in = inl_ff;
      last_in = last_ff;
      rem_in = rem_ff;
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      next_in = next_ff;
      rv_in = rv_ff && !rsp.ready;
      rt_in = rt_ff;
      rl_in = rl_ff;
      sub_a = '0;
      sub_b = '0;
      mul_a = '0;
      mul_b = '0;
      mean = '0;
      req.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               dist_in = req.seg_dist;
               inl_in = req.in_lane;
               last_in = req.last_point;
               if (req.first_segment) begin
                  speed_in = (req.start_speed < SPEED_FLOOR) ? SPEED_FLOOR : req.start_speed;
                  tsum_in = '0;
                  seen_in = 1'b0;
                  done_in = 1'b0;
               end
               state_in = (req.first_segment || !done_ff) ? ST_SQ_A : ST_OUT;
            end
         end
         ST_SQ_A: begin
            mul_a = speed_ff;
            mul_b = speed_ff;
            rem_in = mul_p;
            state_in = ST_SQ_B;
         end
         ST_SQ_B: begin
            mul_a = accel_ff;
            mul_b = dist_ff;
            rem_in = rem_ff + {mul_p[SQ_W-2:0], 1'b0};
            acc_in = '0;
            cnt_in = 5'(ROOT_STEPS - 1);
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            // one root bit per cycle
            sub_a = {1'b0, rem_ff};
            sub_b = {1'b0, trial};
            if (!sub_r[SQ_W]) begin
               rem_in = sub_r[SQ_W-1:0];
               acc_in = (acc_ff >> 1) + bitv;
            end else begin
               acc_in = acc_ff >> 1;
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = ST_MEAN;
         end
         ST_MEAN: begin
            next_in = (acc_ff > SQ_W'(vmax_ff)) ? vmax_ff : acc_ff[SPEED_W-1:0];
            state_in = ST_DIV;
            rem_in = '0;
            acc_in = '0;
            cnt_in = 5'(QUO_W - 1);
         end
         ST_DIV: begin
            mean = sumv[SPEED_W:1];
            if (mean > vmax_ff) mean = vmax_ff;
            if (mean == '0) mean = SPEED_W'(1);
            // restoring divide, one quotient bit per cycle
            sub_a = {rem_ff[SQ_W-1:0], num[cnt_ff]};
            sub_b = (SQ_W+1)'(mean);
            if (!sub_r[SQ_W]) begin
               rem_in = sub_r[SQ_W-1:0];
               acc_in = {acc_ff[SQ_W-2:0], 1'b1};
            end else begin
               rem_in = sub_a[SQ_W-1:0];
               acc_in = {acc_ff[SQ_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 5'd1;
            if (cnt_ff == '0) state_in = ST_ACC;
         end
         ST_ACC: begin
            tsum_in = tadd[TIME_W] ? TIME_MAX : tadd[TIME_W-1:0];
            speed_in = next_ff;
            if (seen_ff && !inl_ff) done_in = 1'b1;
            else seen_in = inl_ff;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (last_ff && rv_ff && !rsp.ready) begin
               // older word still waiting
               state_in = ST_OUT;
            end else begin
               if (last_ff) begin
                  done_in = 1'b1;
                  rv_in = 1'b1;
                  rt_in = seen_ff ? tsum_ff : '0;
                  rl_in = seen_ff;
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign rsp.valid = rv_ff;
   assign rsp.pass_time = rt_ff;
   assign rsp.lane_reached = rl_ff;

endmodule

// ----- tb/sv/lane_passing_time_estimator_top_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lane_passing_time_estimator_top_tb
// drives path segments through the estimator under several acceleration and
// speed cap settings, predicts each passing time in the bench and compares
// every returned word against it, with random stalls on both channels
// ----------------------------------------------------------------------------
module lane_passing_time_estimator_top_tb;
   import lpte_pkg::*;

   localparam int CYCLE_LIMIT = 600000;
   localparam int DRAIN_CYCLES = 80;
   localparam int LONG_HOLD = 700;

   typedef struct packed {
      logic        first_segment;
      logic [15:0] start_speed;
      logic [15:0] seg_dist;
      logic        in_lane;
      logic        last_point;
   } segment_t;

   typedef struct packed {
      logic [31:0] pass_time;
      logic        lane_reached;
   } estimate_t;

   typedef struct packed {
      segment_t  seg;
      logic      typed;
      estimate_t est;
   } directed_row_t;

   logic clock;
   logic reset;
   logic csr_we;
   logic csr_index;
   logic [15:0] csr_wdata;

   lpte_req_if req ();
   lpte_rsp_if rsp ();

   lane_passing_time_estimator_top dut (
      .clock(clock),
      .reset(reset),
      .req(req.sink),
      .rsp(rsp.source),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   // bench copy of the block state
   logic [15:0] accel_reg;
   logic [15:0] cap_reg;
   logic [15:0] speed_now;
   logic [31:0] time_sum;
   logic        lane_seen;
   logic        run_done;

   estimate_t estimate_q[$];
   int errors;
   int cycles;
   bit idle_on;
   bit long_hold_go;
   int hold_left;
   int stall_left;

   directed_row_t directed_rows[] = '{
      '{'{1'b0, 16'd0, 16'd100, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'd0, 16'd40, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b0, 16'd0, 16'd40, 1'b0, 1'b1}, 1'b0, '0},
      '{'{1'b1, 16'd0, 16'd0, 1'b0, 1'b1}, 1'b1, '{32'd0, 1'b0}},
      '{'{1'b1, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'h0000, 16'hFFFF, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'hFFFF, 16'd0, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'd0, 16'd500, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b1, 16'd25, 16'd1, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b1, 16'd26, 16'd300, 1'b0, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'd0, 16'd300, 1'b1, 1'b0}, 1'b0, '0},
      '{'{1'b0, 16'd0, 16'd300, 1'b1, 1'b1}, 1'b0, '0},
      '{'{1'b1, 16'd1000, 16'd800, 1'b0, 1'b1}, 1'b1, '{32'd0, 1'b0}}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [63:0] floor_root(logic [63:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = 0;
      for (int b = 31; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root;
   endfunction

   // advance the bench state by one segment; true when it yields an estimate
   function automatic bit advance_segment(segment_t s, output estimate_t e);
      logic [63:0] sq, nxt, mean, step, total;
      if (s.first_segment) begin
         speed_now = (s.start_speed < SPEED_FLOOR) ? SPEED_FLOOR : s.start_speed;
         time_sum = '0;
         lane_seen = 1'b0;
         run_done = 1'b0;
      end
      if (!run_done) begin
         sq = 64'(speed_now) * 64'(speed_now) + 64'd2 * 64'(accel_reg) * 64'(s.seg_dist);
         nxt = floor_root(sq);
         if (nxt > 64'(cap_reg)) nxt = 64'(cap_reg);
         mean = (64'(speed_now) + nxt) >> 1;
         if (mean > 64'(cap_reg)) mean = 64'(cap_reg);
         if (mean == 0) mean = 1;
         step = (64'(s.seg_dist) << FRAC_BITS) / mean;
         total = 64'(time_sum) + step;
         time_sum = (total > 64'(TIME_MAX)) ? TIME_MAX : total[31:0];
         speed_now = nxt[15:0];
         if (lane_seen && !s.in_lane) run_done = 1'b1;
         else lane_seen = s.in_lane;
      end
      e = '0;
      if (s.last_point) begin
         run_done = 1'b1;
         e.pass_time = lane_seen ? time_sum : 32'd0;
         e.lane_reached = lane_seen;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic void queue_estimate(estimate_t e);
      estimate_q = {estimate_q, e};
   endfunction

   task automatic send_segment(segment_t s, bit typed, estimate_t typed_est);
      estimate_t e;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req.valid <= 1'b0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.first_segment <= s.first_segment;
      req.start_speed <= s.start_speed;
      req.seg_dist <= s.seg_dist;
      req.in_lane <= s.in_lane;
      req.last_point <= s.last_point;
      do @(posedge clock); while (!req.ready);
      if (advance_segment(s, e)) queue_estimate(typed ? typed_est : e);
   endtask

   task automatic write_csr(logic idx, logic [15:0] value);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == CSR_MAX_ACCEL) accel_reg = value;
      else cap_reg = value;
   endtask

   task automatic settle();
      req.valid <= 1'b0;
      while (estimate_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [15:0] pick_dist();
      case ($urandom_range(0, 9))
         0: return 16'($urandom());
         1: return 16'd0;
         default: return 16'($urandom_range(0, 2000));
      endcase
   endfunction

   // one well formed path: approach, lane and exit, each possibly empty; the final segment carries last_point
   task automatic send_path();
      segment_t s;
      int n;
      int lane_from, lane_to;
      n = $urandom_range(1, 9);
      lane_from = $urandom_range(0, n);
      lane_to = $urandom_range(lane_from, n + 1);
      for (int i = 0; i < n; i++) begin
         s.first_segment = (i == 0);
         s.start_speed = ($urandom_range(0, 3) == 0) ? 16'($urandom()) :
                         16'($urandom_range(0, 1500));
         s.seg_dist = pick_dist();
         s.in_lane = (i >= lane_from) && (i < lane_to);
         s.last_point = (i == n - 1);
         send_segment(s, 1'b0, '0);
      end
   endtask

   task automatic random_phase(int words);
      int sent;
      segment_t s;
      sent = 0;
      while (sent < words) begin
         if ($urandom_range(0, 4) != 0) begin
            send_path();
            sent += 5;
         end else begin
            s = segment_t'($bits(segment_t)'({$urandom(), $urandom()}));
            send_segment(s, 1'b0, '0);
            sent++;
         end
      end
      settle();
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp.ready <= 1'b0;
         hold_left <= 0;
         stall_left <= 0;
      end else if (long_hold_go && hold_left == 0) begin
         hold_left <= LONG_HOLD;
         rsp.ready <= 1'b0;
      end else if (hold_left > 1) begin
         hold_left <= hold_left - 1;
         rsp.ready <= 1'b0;
      end else if (stall_left > 0) begin
         hold_left <= 0;
         stall_left <= stall_left - 1;
         rsp.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
         hold_left <= 0;
         stall_left <= $urandom_range(0, 17);
         rsp.ready <= 1'b0;
      end else begin
         hold_left <= 0;
         rsp.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      estimate_t want;
      if (!reset && rsp.valid && rsp.ready) begin
         if (estimate_q.size() == 0) begin
            $display("%0t: unexpected word time=%0d reached=%0b", $time,
                     rsp.pass_time, rsp.lane_reached);
            errors++;
         end else begin
            want = estimate_q.pop_front();
            if (rsp.pass_time !== want.pass_time) begin
               $display("%0t: pass_time expected %0d actual %0d", $time,
                        want.pass_time, rsp.pass_time);
               errors++;
            end
            if (rsp.lane_reached !== want.lane_reached) begin
               $display("%0t: lane_reached expected %0b actual %0b", $time,
                        want.lane_reached, rsp.lane_reached);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("lane_passing_time_estimator_top_tb: errors");
         $finish;
      end
   end

   initial begin
      segment_t s;
      errors = 0;
      cycles = 0;
      idle_on = 1'b1;
      long_hold_go = 1'b0;
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = CSR_MAX_ACCEL;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.first_segment = 1'b0;
      req.start_speed = '0;
      req.seg_dist = '0;
      req.in_lane = 1'b0;
      req.last_point = 1'b0;
      accel_reg = 16'd256;
      cap_reg = 16'd711;
      speed_now = '0;
      time_sum = '0;
      lane_seen = 1'b0;
      run_done = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i])
         send_segment(directed_rows[i].seg, directed_rows[i].typed, directed_rows[i].est);
      settle();

      // receiver holds off while paths keep coming, so the block backs up
      long_hold_go <= 1'b1;
      @(posedge clock);
      long_hold_go <= 1'b0;
      repeat (6) send_path();
      settle();
      random_phase(60);

      // cap of one: every step is the distance scaled, drives the sum to saturation
      write_csr(CSR_MAX_ACCEL, 16'd0);
      write_csr(CSR_MAX_SPEED, 16'd1);
      for (int i = 0; i < 260; i++) begin
         s = '{(i == 0), 16'd0, 16'hFFFF, 1'b1, (i == 259)};
         send_segment(s, 1'b0, '0);
      end
      settle();
      random_phase(20);

      write_csr(CSR_MAX_ACCEL, 16'hFFFF);
      write_csr(CSR_MAX_SPEED, 16'hFFFF);
      random_phase(40);

      // zero cap takes the divide-by-one path
      write_csr(CSR_MAX_SPEED, 16'd0);
      random_phase(20);

      write_csr(CSR_MAX_ACCEL, 16'($urandom()));
      write_csr(CSR_MAX_SPEED, 16'($urandom_range(1, 65535)));
      random_phase(40);

      idle_on = 1'b0;
      write_csr(CSR_MAX_ACCEL, 16'd256);
      write_csr(CSR_MAX_SPEED, 16'd711);
      random_phase(40);

      if (errors == 0) $display("lane_passing_time_estimator_top_tb: clean");
      else $display("lane_passing_time_estimator_top_tb: errors");
      $finish;
   end

endmodule

// ----- sim.f -----
design/lpte_pkg.sv
design/lpte_if.sv
design/lane_passing_time_estimator_top.sv
tb/sv/lane_passing_time_estimator_top_tb.sv
